/* rtl/rar_pkg.sv */
// Shared codes and control types for the rational arithmetic reduce block.
package rar_pkg;

    localparam logic [1:0] REQ_ADD = 2'd0;
    localparam logic [1:0] REQ_SUB = 2'd1;
    localparam logic [1:0] REQ_MUL = 2'd2;
    localparam logic [1:0] REQ_DIV = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_DIV_ZERO = 2'd2;

    // Per-item control decided by the front end: status and the sign of each product.
    typedef struct packed {
        logic [1:0] status;
        logic       neg_a;
        logic       neg_b;
        logic       neg_d;
    } t_ctrl;

    localparam int CTRL_BITS = $bits(t_ctrl);

endpackage

/* rtl/rar_front.sv */
// Front end: classifies an item and picks the magnitude pairs for each cross product.
module rar_front #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic [1:0]               i_req_type,
    input  logic [OPERAND_WIDTH-1:0] i_a_num,
    input  logic [OPERAND_WIDTH-1:0] i_a_den,
    input  logic [OPERAND_WIDTH-1:0] i_b_num,
    input  logic [OPERAND_WIDTH-1:0] i_b_den,
    output rar_pkg::t_ctrl           o_ctrl,
    output logic [OPERAND_WIDTH-1:0] o_xa,
    output logic [OPERAND_WIDTH-1:0] o_ya,
    output logic [OPERAND_WIDTH-1:0] o_xb,
    output logic [OPERAND_WIDTH-1:0] o_yb,
    output logic [OPERAND_WIDTH-1:0] o_xd,
    output logic [OPERAND_WIDTH-1:0] o_yd
);
    import rar_pkg::*;

    localparam int W = OPERAND_WIDTH;

    logic         an_s, ad_s, bn_s, bd_s;
    logic [W-1:0] an_m, ad_m, bn_m, bd_m;

    assign an_s = i_a_num[W-1];
    assign ad_s = i_a_den[W-1];
    assign bn_s = i_b_num[W-1];
    assign bd_s = i_b_den[W-1];

    // The most negative code maps to its true magnitude in W unsigned bits.
    assign an_m = an_s ? (~i_a_num + 1'b1) : i_a_num;
    assign ad_m = ad_s ? (~i_a_den + 1'b1) : i_a_den;
    assign bn_m = bn_s ? (~i_b_num + 1'b1) : i_b_num;
    assign bd_m = bd_s ? (~i_b_den + 1'b1) : i_b_den;

    always_comb begin
        o_ctrl = '0;
        o_xa   = an_m;
        o_ya   = bd_m;
        o_xb   = '0;
        o_yb   = '0;
        o_xd   = ad_m;
        o_yd   = bd_m;
        o_ctrl.neg_a = an_s ^ bd_s;
        o_ctrl.neg_d = ad_s ^ bd_s;
        case (i_req_type)
            REQ_ADD, REQ_SUB: begin
                o_xb = bn_m;
                o_yb = ad_m;
                o_ctrl.neg_b = bn_s ^ ad_s ^ (i_req_type == REQ_SUB);
            end
            REQ_MUL: begin
                o_ya = bn_m;
                o_ctrl.neg_a = an_s ^ bn_s;
            end
            REQ_DIV: begin
                o_yd = bn_m;
                o_ctrl.neg_d = ad_s ^ bn_s;
            end
            default: begin
                o_xb = '0;
            end
        endcase
        if (ad_m == '0 || bd_m == '0) begin
            o_ctrl.status = ST_ZERO_DEN;
        end else if (i_req_type == REQ_DIV && bn_m == '0) begin
            o_ctrl.status = ST_DIV_ZERO;
        end else begin
            o_ctrl.status = ST_OK;
        end
    end

endmodule

/* rtl/rar_fifo.sv */
// Two-entry queue between the front end and the back end.
module rar_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

/* rtl/rar_div.sv */
// Restoring divider, one quotient bit per cycle.
module rar_div #(
    parameter int NW = 32,
    parameter int DW = 31
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [NW-1:0] o_quot,
    output logic [DW-1:0] o_rem
);
    localparam int CW = $clog2(NW + 1);

    logic          r_busy, r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_q;
    logic [DW-1:0] r_r, r_d;
    logic [DW:0]   t, diff;
    logic          ge;

    assign t      = {r_r, r_q[NW-1]};
    assign ge     = (t >= {1'b0, r_d});
    assign diff   = t - {1'b0, r_d};
    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_r <= '0;
            r_d <= i_divisor;
        end else if (r_busy) begin
            r_q <= {r_q[NW-2:0], ge};
            r_r <= ge ? diff[DW-1:0] : t[DW-1:0];
        end
    end

endmodule

/* rtl/rar_back.sv */
// Back end: cross products, binary gcd, reduction divides and the output register.
module rar_back #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    input  rar_pkg::t_ctrl             i_ctrl,
    input  logic [OPERAND_WIDTH-1:0]   i_xa,
    input  logic [OPERAND_WIDTH-1:0]   i_ya,
    input  logic [OPERAND_WIDTH-1:0]   i_xb,
    input  logic [OPERAND_WIDTH-1:0]   i_yb,
    input  logic [OPERAND_WIDTH-1:0]   i_xd,
    input  logic [OPERAND_WIDTH-1:0]   i_yd,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [1:0]                 o_status,
    output logic [2*OPERAND_WIDTH:0]   o_red_num,
    output logic [2*OPERAND_WIDTH-2:0] o_red_den,
    output logic [2*OPERAND_WIDTH:0]   o_whole_part,
    output logic [2*OPERAND_WIDTH-3:0] o_rem_mag
);
    import rar_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int MW = 2 * W;
    localparam int DW = 2 * W - 1;
    localparam int KW = $clog2(2 * W);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MULA = 4'd1;
    localparam logic [3:0] S_MULB = 4'd2;
    localparam logic [3:0] S_MULD = 4'd3;
    localparam logic [3:0] S_SUM  = 4'd4;
    localparam logic [3:0] S_GCD  = 4'd5;
    localparam logic [3:0] S_DIV1 = 4'd6;
    localparam logic [3:0] S_DIV2 = 4'd7;
    localparam logic [3:0] S_DIV3 = 4'd8;

    logic [3:0]    r_state, n_state;
    logic          r_ov, n_ov;
    logic          r_div_run, n_div_run;
    t_ctrl         r_ctrl, n_ctrl;
    logic [W-1:0]  r_xa, r_ya, r_xb, r_yb, r_xd, r_yd;
    logic [MW-1:0] r_pa, n_pa, r_pb, n_pb, r_pd, n_pd;
    logic [MW-1:0] r_nmag, n_nmag, r_u, n_u, r_rn, n_rn;
    logic          r_nneg, n_nneg;
    logic [DW-1:0] r_dmag, n_dmag, r_v, n_v, r_g, n_g, r_rd, n_rd;
    logic [KW-1:0] r_k, n_k;
    logic [1:0]    r_status, n_status;
    logic [MW:0]   r_onum, n_onum, r_owhole, n_owhole;
    logic [DW-1:0] r_oden, n_oden;
    logic [MW-3:0] r_orem, n_orem;

    logic [W-1:0]  mul_x, mul_y;
    logic [MW-1:0] prod;
    logic [MW+1:0] ta, tb, s, s_abs;
    logic [MW-1:0] s_mag;
    logic          s_neg;

    logic          div_start, div_done;
    logic [MW-1:0] div_n, div_quot;
    logic [DW-1:0] div_d, div_rem;

    rar_div #(.NW(MW), .DW(DW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_n),
        .i_divisor  (div_d),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // One shared multiplier, used for three products in states S_MULA, S_MULB and S_MULD.
    always_comb begin
        case (r_state)
            S_MULA: begin
                mul_x = r_xa;
                mul_y = r_ya;
            end
            S_MULB: begin
                mul_x = r_xb;
                mul_y = r_yb;
            end
            default: begin
                mul_x = r_xd;
                mul_y = r_yd;
            end
        endcase
    end
    assign prod = mul_x * mul_y;

    // Signed sum of the two numerator terms, then its magnitude.
    assign ta    = r_ctrl.neg_a ? ({(MW+2){1'b0}} - {2'b00, r_pa}) : {2'b00, r_pa};
    assign tb    = r_ctrl.neg_b ? ({(MW+2){1'b0}} - {2'b00, r_pb}) : {2'b00, r_pb};
    assign s     = ta + tb;
    assign s_neg = s[MW+1];
    assign s_abs = s_neg ? ({(MW+2){1'b0}} - s) : s;
    assign s_mag = s_abs[MW-1:0];

    always_comb begin
        case (r_state)
            S_DIV1: begin
                div_n = r_nmag;
                div_d = r_g;
            end
            S_DIV2: begin
                div_n = {1'b0, r_dmag};
                div_d = r_g;
            end
            default: begin
                div_n = r_rn;
                div_d = r_rd;
            end
        endcase
    end

    assign o_pop        = (r_state == S_IDLE) && i_q_valid && !r_ov;
    assign o_out_valid  = r_ov;
    assign o_status     = r_status;
    assign o_red_num    = r_onum;
    assign o_red_den    = r_oden;
    assign o_whole_part = r_owhole;
    assign o_rem_mag    = r_orem;

    always_comb begin
        n_state   = r_state;
        n_ov      = r_ov;
        n_div_run = r_div_run;
        n_ctrl    = r_ctrl;
        n_pa      = r_pa;
        n_pb      = r_pb;
        n_pd      = r_pd;
        n_nmag    = r_nmag;
        n_nneg    = r_nneg;
        n_dmag    = r_dmag;
        n_u       = r_u;
        n_v       = r_v;
        n_k       = r_k;
        n_g       = r_g;
        n_rn      = r_rn;
        n_rd      = r_rd;
        n_status  = r_status;
        n_onum    = r_onum;
        n_oden    = r_oden;
        n_owhole  = r_owhole;
        n_orem    = r_orem;
        div_start = 1'b0;

        if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    n_ctrl = i_ctrl;
                    if (i_ctrl.status != ST_OK) begin
                        n_ov     = 1'b1;
                        n_status = i_ctrl.status;
                        n_onum   = '0;
                        n_oden   = '0;
                        n_owhole = '0;
                        n_orem   = '0;
                    end else begin
                        n_state = S_MULA;
                    end
                end
            end
            S_MULA: begin
                n_pa    = prod;
                n_state = S_MULB;
            end
            S_MULB: begin
                n_pb    = prod;
                n_state = S_MULD;
            end
            S_MULD: begin
                n_pd    = prod;
                n_state = S_SUM;
            end
            S_SUM: begin
                n_nmag  = s_mag;
                n_nneg  = (s_neg ^ r_ctrl.neg_d) && (s_mag != '0);
                n_dmag  = r_pd[DW-1:0];
                n_u     = s_mag;
                n_v     = r_pd[DW-1:0];
                n_k     = '0;
                n_state = S_GCD;
            end
            S_GCD: begin
                if (r_u == '0) begin
                    n_g     = r_v << r_k;
                    n_state = S_DIV1;
                end else if (!r_u[0] && !r_v[0]) begin
                    n_u = r_u >> 1;
                    n_v = r_v >> 1;
                    n_k = r_k + 1'b1;
                end else if (!r_u[0]) begin
                    n_u = r_u >> 1;
                end else if (!r_v[0]) begin
                    n_v = r_v >> 1;
                end else if (r_u >= {1'b0, r_v}) begin
                    n_u = r_u - {1'b0, r_v};
                end else begin
                    n_v = r_v - r_u[DW-1:0];
                end
            end
            S_DIV1, S_DIV2, S_DIV3: begin
                if (!r_div_run) begin
                    div_start = 1'b1;
                    n_div_run = 1'b1;
                end else if (div_done) begin
                    n_div_run = 1'b0;
                    if (r_state == S_DIV1) begin
                        n_rn    = div_quot;
                        n_state = S_DIV2;
                    end else if (r_state == S_DIV2) begin
                        n_rd    = div_quot[DW-1:0];
                        n_state = S_DIV3;
                    end else begin
                        n_ov     = 1'b1;
                        n_status = ST_OK;
                        n_onum   = r_nneg ? ({(MW+1){1'b0}} - {1'b0, r_rn})
                                          : {1'b0, r_rn};
                        n_oden   = r_rd;
                        n_owhole = r_nneg ? ({(MW+1){1'b0}} - {1'b0, div_quot})
                                          : {1'b0, div_quot};
                        n_orem   = div_rem[MW-3:0];
                        n_state  = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ov      <= 1'b0;
            r_div_run <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ov      <= n_ov;
            r_div_run <= n_div_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_xa <= i_xa;
            r_ya <= i_ya;
            r_xb <= i_xb;
            r_yb <= i_yb;
            r_xd <= i_xd;
            r_yd <= i_yd;
        end
        r_ctrl   <= n_ctrl;
        r_pa     <= n_pa;
        r_pb     <= n_pb;
        r_pd     <= n_pd;
        r_nmag   <= n_nmag;
        r_nneg   <= n_nneg;
        r_dmag   <= n_dmag;
        r_u      <= n_u;
        r_v      <= n_v;
        r_k      <= n_k;
        r_g      <= n_g;
        r_rn     <= n_rn;
        r_rd     <= n_rd;
        r_status <= n_status;
        r_onum   <= n_onum;
        r_oden   <= n_oden;
        r_owhole <= n_owhole;
        r_orem   <= n_orem;
    end

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_status != ST_OK) |-> (r_onum == '0 && r_oden == '0 &&
                                         r_owhole == '0 && r_orem == '0))
        else $error("error result carries nonzero fields");

    a_den_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_status == ST_OK) |-> (r_oden != '0))
        else $error("valid result has zero denominator");

    a_gcd_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == S_GCD && r_state != S_GCD) |-> ($past(r_u) == '0))
        else $error("gcd loop left before it converged");

endmodule

/* rtl/rational_arith_reduce_top.sv */
// Top level of the rational arithmetic block with gcd reduction.
// Each transfer on the input channel carries two fractions and an operation (add, subtract,
// multiply, divide); one result transfer follows per item with the reduced fraction, its
// whole part truncated toward zero and the remainder magnitude. A zero denominator gives
// status ST_ZERO_DEN, and a divide by a zero fraction gives ST_DIV_ZERO, both with zeroed
// fields. The front end classifies items and sets up the product operands in the same cycle
// it takes them, then parks them in a two-entry queue, so up to two items can be taken while
// the back end is busy. The back end handles one item at a time: three products on its single
// shared multiplier, a sum step that fixes the sign, a binary gcd of shift and subtract steps,
// and three passes of a one-bit-per-cycle divider; error items skip these steps. The result
// sits in an output register until taken, and the back end starts the next item only after
// that.
module rational_arith_reduce_top #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [1:0]                 i_req_type,
    input  logic [OPERAND_WIDTH-1:0]   i_a_num,
    input  logic [OPERAND_WIDTH-1:0]   i_a_den,
    input  logic [OPERAND_WIDTH-1:0]   i_b_num,
    input  logic [OPERAND_WIDTH-1:0]   i_b_den,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [1:0]                 o_status,
    output logic [2*OPERAND_WIDTH:0]   o_red_num,
    output logic [2*OPERAND_WIDTH-2:0] o_red_den,
    output logic [2*OPERAND_WIDTH:0]   o_whole_part,
    output logic [2*OPERAND_WIDTH-3:0] o_rem_mag
);
    import rar_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int QW = CTRL_BITS + 6 * W;

    t_ctrl         f_ctrl, q_ctrl;
    logic [W-1:0]  f_xa, f_ya, f_xb, f_yb, f_xd, f_yd;
    logic [QW-1:0] q_in, q_out;
    logic          q_full, q_valid, q_pop, q_push;

    rar_front #(.OPERAND_WIDTH(W)) u_front (
        .i_req_type (i_req_type),
        .i_a_num    (i_a_num),
        .i_a_den    (i_a_den),
        .i_b_num    (i_b_num),
        .i_b_den    (i_b_den),
        .o_ctrl     (f_ctrl),
        .o_xa       (f_xa),
        .o_ya       (f_ya),
        .o_xb       (f_xb),
        .o_yb       (f_yb),
        .o_xd       (f_xd),
        .o_yd       (f_yd)
    );

    // An input transfer completes whenever the queue has room.
    assign o_in_stall = q_full;
    assign q_push     = i_in_valid && !q_full;
    assign q_in       = {f_ctrl, f_xa, f_ya, f_xb, f_yb, f_xd, f_yd};

    rar_fifo #(.WIDTH(QW)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    assign q_ctrl = t_ctrl'(q_out[6*W +: CTRL_BITS]);

    rar_back #(.OPERAND_WIDTH(W)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_ctrl       (q_ctrl),
        .i_xa         (q_out[5*W +: W]),
        .i_ya         (q_out[4*W +: W]),
        .i_xb         (q_out[3*W +: W]),
        .i_yb         (q_out[2*W +: W]),
        .i_xd         (q_out[1*W +: W]),
        .i_yd         (q_out[0 +: W]),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_red_num    (o_red_num),
        .o_red_den    (o_red_den),
        .o_whole_part (o_whole_part),
        .o_rem_mag    (o_rem_mag)
    );

endmodule

/* sim/rational_arith_reduce_top_tb.sv */
// Testbench for the rational arithmetic block: self-checking, randomized, with idling.
`timescale 1ns / 1ps

module rational_arith_reduce_top_tb;
    import rar_pkg::*;

    localparam int W        = 16;
    localparam int NUM_W    = 2 * W + 1;
    localparam int DEN_W    = 2 * W - 1;
    localparam int REM_W    = 2 * W - 2;
    localparam int N_RANDOM = 1600;
    // The limit covers the back-end time of an item plus a long stall or gap.
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]   req_type;
        logic [W-1:0] a_num;
        logic [W-1:0] a_den;
        logic [W-1:0] b_num;
        logic [W-1:0] b_den;
    } t_fraction_pair;

    typedef struct packed {
        logic [1:0]       status;
        logic [NUM_W-1:0] red_num;
        logic [DEN_W-1:0] red_den;
        logic [NUM_W-1:0] whole_part;
        logic [REM_W-1:0] rem_mag;
    } t_mixed_result;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    logic [1:0]       i_req_type;
    logic [W-1:0]     i_a_num;
    logic [W-1:0]     i_a_den;
    logic [W-1:0]     i_b_num;
    logic [W-1:0]     i_b_den;
    logic             o_out_valid;
    logic             i_out_stall;
    logic [1:0]       o_status;
    logic [NUM_W-1:0] o_red_num;
    logic [DEN_W-1:0] o_red_den;
    logic [NUM_W-1:0] o_whole_part;
    logic [REM_W-1:0] o_rem_mag;

    rational_arith_reduce_top #(.OPERAND_WIDTH(W)) i_dut (.*);

    t_fraction_pair pending_items[$];
    t_mixed_result  expected_results[$];
    int             error_count = 0;
    int             watchdog = 0;
    bit             hold_sender = 0;  // pauses the driver so the block drains
    bit             no_idle = 0;      // a stretch with no idling on either side

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Signed value of a field, as a 64-bit integer. The most negative value maps to -2^(W-1).
    function automatic longint field_value(logic [W-1:0] raw);
        return longint'($signed(raw));
    endfunction

    function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Computes the reduced mixed-number form of one item.
    function automatic t_mixed_result reduce_fraction_pair(t_fraction_pair p);
        t_mixed_result   r;
        longint          an, ad, bn, bd, num, den, q;
        longint unsigned g, num_mag, rem;
        an = field_value(p.a_num);
        ad = field_value(p.a_den);
        bn = field_value(p.b_num);
        bd = field_value(p.b_den);
        r = '0;
        if (ad == 0 || bd == 0) begin
            r.status = ST_ZERO_DEN;
            return r;
        end
        if (p.req_type == REQ_DIV && bn == 0) begin
            r.status = ST_DIV_ZERO;
            return r;
        end
        case (p.req_type)
            REQ_ADD: begin num = an * bd + bn * ad; den = ad * bd; end
            REQ_SUB: begin num = an * bd - bn * ad; den = ad * bd; end
            REQ_MUL: begin num = an * bn;           den = ad * bd; end
            default: begin num = an * bd;           den = ad * bn; end
        endcase
        // Move the sign of the denominator onto the numerator.
        if (den < 0) begin
            den = -den;
            num = -num;
        end
        num_mag = (num < 0) ? -num : num;
        g = euclid_gcd(num_mag, den);
        if (g != 0) begin
            num = num / longint'(g);
            den = den / longint'(g);
            num_mag = num_mag / g;
        end
        q   = num / den;  // truncates toward zero
        rem = num_mag % den;
        r.status     = ST_OK;
        r.red_num    = num[NUM_W-1:0];
        r.red_den    = den[DEN_W-1:0];
        r.whole_part = q[NUM_W-1:0];
        r.rem_mag    = rem[REM_W-1:0];
        return r;
    endfunction

    function automatic logic [W-1:0] random_field();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'hffff;
            3:       return 16'($urandom_range(0, 2));
            4, 5:    return 16'($signed($urandom_range(0, 40)) - 20);
            default: return 16'($urandom);
        endcase
    endfunction

    // Driver: presents queued items; valid only falls when no item is offered next.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(reduce_fraction_pair(pending_items.pop_front()));
            end
            if ((i_in_valid && o_in_stall) ||
                (pending_items.size() > 0 && !hold_sender &&
                 (no_idle || $urandom_range(0, 99) >= 13))) begin
                // A stalled transfer keeps its payload; otherwise the next item goes out.
                i_in_valid <= pending_items.size() > 0;
                if (pending_items.size() > 0) begin
                    {i_req_type, i_a_num, i_a_den, i_b_num, i_b_den} <= pending_items[0];
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: random back-pressure on results and a field-by-field comparison.
    always @(posedge i_clk) begin
        t_mixed_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no item outstanding");
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        error_count++;
                    end
                    if (o_red_num !== want.red_num) begin
                        $error("red_num: expected %0d, got %0d",
                               $signed(want.red_num), $signed(o_red_num));
                        error_count++;
                    end
                    if (o_red_den !== want.red_den) begin
                        $error("red_den: expected %0d, got %0d", want.red_den, o_red_den);
                        error_count++;
                    end
                    if (o_whole_part !== want.whole_part) begin
                        $error("whole_part: expected %0d, got %0d",
                               $signed(want.whole_part), $signed(o_whole_part));
                        error_count++;
                    end
                    if (o_rem_mag !== want.rem_mag) begin
                        $error("rem_mag: expected %0d, got %0d", want.rem_mag, o_rem_mag);
                        error_count++;
                    end
                end
            end
            i_out_stall <= !no_idle && ($urandom_range(0, 99) < 13);
        end
    end

    // Watchdog: counts cycles without any transfer on either channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            watchdog <= 0;
        end else if (watchdog >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            watchdog <= watchdog + 1;
        end
    end

    task automatic queue_item(logic [1:0] op, logic [W-1:0] an, logic [W-1:0] ad,
                              logic [W-1:0] bn, logic [W-1:0] bd);
        pending_items.push_back('{op, an, ad, bn, bd});
    endtask

    initial begin
        t_fraction_pair item;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_out_stall = 1'b0;
        i_req_type  = REQ_ADD;
        i_a_num     = '0;
        i_a_den     = '0;
        i_b_num     = '0;
        i_b_den     = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: every operation, field extremes, both error cases and a zero result.
        queue_item(REQ_ADD, 16'd1, 16'd2, 16'd1, 16'd3);
        queue_item(REQ_SUB, 16'd1, 16'd2, 16'd1, 16'd2);     // zero result
        queue_item(REQ_MUL, -16'sd3, 16'd4, 16'd2, -16'sd9);
        queue_item(REQ_DIV, 16'd7, 16'd3, -16'sd2, 16'd5);
        queue_item(REQ_ADD, 16'd1, 16'd0, 16'd1, 16'd1);     // zero first denominator
        queue_item(REQ_DIV, 16'd1, 16'd1, 16'd0, 16'd0);     // zero denominator wins
        queue_item(REQ_DIV, 16'd5, 16'd1, 16'd0, 16'd3);     // divide by a zero fraction
        queue_item(REQ_MUL, 16'd0, 16'd5, 16'd9, 16'd0);     // zero second denominator
        queue_item(REQ_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        queue_item(REQ_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
        queue_item(REQ_MUL, 16'h8000, 16'd1, 16'h8000, 16'd1);
        queue_item(REQ_DIV, 16'h8000, 16'd1, 16'd1, 16'h7fff);
        queue_item(REQ_DIV, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
        queue_item(REQ_ADD, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        queue_item(REQ_SUB, 16'h7fff, 16'd1, 16'h8000, 16'd1);
        queue_item(REQ_MUL, 16'h7fff, 16'd3, 16'hffff, 16'h8001);
        queue_item(REQ_DIV, 16'hffff, 16'd7, 16'h8000, 16'hfffe);

        // Pause the sender once until the block has drained completely.
        wait (pending_items.size() == 0);
        hold_sender = 1;
        wait (expected_results.size() == 0);
        hold_sender = 0;

        for (int i = 0; i < N_RANDOM; i++) begin
            item.req_type = 2'($urandom_range(0, 3));
            item.a_num    = random_field();
            item.a_den    = random_field();
            item.b_num    = random_field();
            item.b_den    = random_field();
            // A few zero denominators, not so many that real work becomes rare.
            if (item.a_den == 0 && $urandom_range(0, 3) != 0) item.a_den = 16'd1;
            if (item.b_den == 0 && $urandom_range(0, 3) != 0) item.b_den = 16'hffff;
            pending_items.push_back(item);
            // A stretch in the middle runs with no idling on either side.
            if (i == N_RANDOM / 2) no_idle = 1;
            if (i == N_RANDOM / 2 + 200) begin
                wait (pending_items.size() < 50);
                no_idle = 0;
            end
            if (pending_items.size() > 64) wait (pending_items.size() < 16);
        end

        wait (pending_items.size() == 0 && !i_in_valid);
        wait (expected_results.size() == 0);
        repeat (300) @(posedge i_clk);

        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Results that arrive after the last expected one are caught by the monitor.
endmodule
